// ----- src/bgsc_pkg.sv -----
// Types, widths and codes shared by the battery gauge and supply check block.
package bgsc_pkg;

  localparam int SAMPLES_LOG2 = 4;
  localparam int ADC_BITS     = 10;

  localparam int SUM_W   = ADC_BITS + SAMPLES_LOG2;
  localparam int CNT_W   = SAMPLES_LOG2 + 1;
  localparam int QUOT_W  = 16;
  localparam int QCNT_W  = $clog2(QUOT_W);
  localparam int THR_W   = 16;
  localparam int NUM_THR = 5;
  localparam int LVL_W   = 3;
  localparam int STS_W   = 2;
  localparam int IDX_W   = 3;
  localparam int CFG_W   = 16;

  localparam logic [IDX_W-1:0] REG_THR_1     = 3'd0;
  localparam logic [IDX_W-1:0] REG_THR_2     = 3'd1;
  localparam logic [IDX_W-1:0] REG_THR_3     = 3'd2;
  localparam logic [IDX_W-1:0] REG_THR_4     = 3'd3;
  localparam logic [IDX_W-1:0] REG_THR_5     = 3'd4;
  localparam logic [IDX_W-1:0] REG_NUMERATOR = 3'd5;
  localparam logic [IDX_W-1:0] REG_SHORT_LIM = 3'd6;

  localparam logic [THR_W-1:0]    RST_THR_1     = 16'd27;
  localparam logic [THR_W-1:0]    RST_THR_2     = 16'd32;
  localparam logic [THR_W-1:0]    RST_THR_3     = 16'd34;
  localparam logic [THR_W-1:0]    RST_THR_4     = 16'd36;
  localparam logic [THR_W-1:0]    RST_THR_5     = 16'd38;
  localparam logic [QUOT_W-1:0]   RST_NUMERATOR = 16'd25600;
  localparam logic [ADC_BITS-1:0] RST_SHORT_LIM = ADC_BITS'(96);

  localparam logic KIND_BATTERY = 1'b0;
  localparam logic KIND_SUPPLY  = 1'b1;

  localparam logic [STS_W-1:0] STATUS_PIN    = 2'd0;
  localparam logic [STS_W-1:0] STATUS_NORMAL = 2'd1;
  localparam logic [STS_W-1:0] STATUS_SHORT  = 2'd2;

  localparam logic [LVL_W-1:0] PHASE_LAST = 3'd5;

  typedef struct packed {
    logic                measure_kind;
    logic [ADC_BITS-1:0] sample;
    logic                charging_n;
    logic                standby_n;
  } in_t;

  typedef struct packed {
    logic             result_kind;
    logic [LVL_W-1:0] level;
    logic [STS_W-1:0] supply_status;
    logic             output_off;
  } out_t;

endpackage

// ----- src/battery_gauge_and_supply_check_top.sv -----
// Battery gauge and supply check: sample windowing, serial divider, grading and supply short check.
//
//   channel | dir | handshake            | payload
//   --------+-----+----------------------+----------------------------------
//   in      | in  | in_valid / in_ready  | in_data  (measure_kind, sample, pins)
//   out     | out | out_valid / out_ready| out_data (kind, level, status, off)
//   cfg     | in  | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A beat that does not close a battery window finishes in its accept cycle;
// a result, if any, shows in the output register the cycle after.
// A beat that closes a battery window runs the restoring divider, one
// quotient bit a cycle into the 16-bit quotient, then a grading state that waits for a free output register.
// in_ready is low while the divider runs or grades and while a result is stalled.
// rst_n is synchronous, active low; cfg_ready is always high.
module battery_gauge_and_supply_check_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  bgsc_pkg::in_t             in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output bgsc_pkg::out_t            out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [bgsc_pkg::IDX_W-1:0] cfg_index,
  input  logic [bgsc_pkg::CFG_W-1:0] cfg_data
);
  import bgsc_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  localparam logic [CNT_W-1:0]  CNT_LAST  = CNT_W'((1 << SAMPLES_LOG2) - 1);
  localparam logic [QCNT_W-1:0] QCNT_LAST = QCNT_W'(QUOT_W - 1);

  logic [THR_W-1:0]    thr_r [NUM_THR];
  logic [QUOT_W-1:0]   num_r;
  logic [ADC_BITS-1:0] short_lim_r;

  logic [1:0]          state_r, state_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                wkind_r, wkind_nxt;
  logic [LVL_W-1:0]    phase_r, phase_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_t                out_data_r, out_data_nxt;
  logic [ADC_BITS-1:0] div_rem_r, div_rem_nxt;
  logic [QUOT_W-1:0]   div_q_r, div_q_nxt;
  logic [ADC_BITS-1:0] div_d_r, div_d_nxt;
  logic [QCNT_W-1:0]   div_cnt_r, div_cnt_nxt;
  logic                chg_n_r, chg_n_nxt;

  logic                out_free;
  logic                in_acc;
  logic                restart;
  logic [SUM_W-1:0]    new_sum;
  logic [CNT_W-1:0]    base_cnt;
  logic [ADC_BITS-1:0] avg;
  logic [ADC_BITS:0]   shifted;
  logic                ge;
  logic [LVL_W-1:0]    grade;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE) && out_free;
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign restart  = in_data.measure_kind != wkind_r;
  assign base_cnt = restart ? '0 : cnt_r;
  assign new_sum  = (restart ? SUM_W'(0) : sum_r) + SUM_W'(in_data.sample);
  assign avg      = new_sum[SUM_W-1:SAMPLES_LOG2];

  assign shifted = {div_rem_r, div_q_r[QUOT_W-1]};
  assign ge      = shifted >= {1'b0, div_d_r};

  always_comb begin
    grade = LVL_W'(NUM_THR);
    for (int i = NUM_THR - 1; i >= 0; i--) begin
      if (div_q_r < thr_r[i]) grade = LVL_W'(i);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    wkind_nxt     = wkind_r;
    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    div_rem_nxt   = div_rem_r;
    div_q_nxt     = div_q_r;
    div_d_nxt     = div_d_r;
    div_cnt_nxt   = div_cnt_r;
    chg_n_nxt     = chg_n_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          out_data_nxt = '{result_kind: in_data.measure_kind, level: '0,
                           supply_status: STATUS_PIN, output_off: 1'b0};
          if (in_data.measure_kind == KIND_SUPPLY &&
              (!in_data.charging_n || !in_data.standby_n)) begin
            sum_nxt       = '0;
            cnt_nxt       = '0;
            wkind_nxt     = KIND_SUPPLY;
            out_valid_nxt = 1'b1;
          end else if (base_cnt == CNT_LAST) begin
            sum_nxt   = '0;
            cnt_nxt   = '0;
            wkind_nxt = in_data.measure_kind;
            if (in_data.measure_kind == KIND_SUPPLY) begin
              phase_nxt     = '0;
              out_valid_nxt = 1'b1;
              if (avg < short_lim_r) begin
                out_data_nxt.supply_status = STATUS_SHORT;
                out_data_nxt.output_off    = 1'b1;
              end else begin
                out_data_nxt.supply_status = STATUS_NORMAL;
              end
            end else begin
              div_rem_nxt = '0;
              div_q_nxt   = num_r;
              div_d_nxt   = avg;
              div_cnt_nxt = '0;
              chg_n_nxt   = in_data.charging_n;
              state_nxt   = ST_DIV;
            end
          end else begin
            sum_nxt   = new_sum;
            cnt_nxt   = base_cnt + CNT_W'(1);
            wkind_nxt = in_data.measure_kind;
          end
        end
      end
      ST_DIV: begin
        div_rem_nxt = ge ? ADC_BITS'(shifted - {1'b0, div_d_r}) : shifted[ADC_BITS-1:0];
        div_q_nxt   = {div_q_r[QUOT_W-2:0], ge};
        div_cnt_nxt = div_cnt_r + QCNT_W'(1);
        if (div_cnt_r == QCNT_LAST) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{result_kind: KIND_BATTERY, level: grade,
                            supply_status: STATUS_PIN, output_off: 1'b0};
          if (!chg_n_r) begin
            out_data_nxt.level = phase_r;
            phase_nxt = (phase_r >= PHASE_LAST) ? '0 : phase_r + LVL_W'(1);
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sum_r       <= '0;
      cnt_r       <= '0;
      wkind_r     <= KIND_BATTERY;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      cnt_r       <= cnt_nxt;
      wkind_r     <= wkind_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    div_rem_r  <= div_rem_nxt;
    div_q_r    <= div_q_nxt;
    div_d_r    <= div_d_nxt;
    div_cnt_r  <= div_cnt_nxt;
    chg_n_r    <= chg_n_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r[0]    <= RST_THR_1;
      thr_r[1]    <= RST_THR_2;
      thr_r[2]    <= RST_THR_3;
      thr_r[3]    <= RST_THR_4;
      thr_r[4]    <= RST_THR_5;
      num_r       <= RST_NUMERATOR;
      short_lim_r <= RST_SHORT_LIM;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_THR_1:     thr_r[0]    <= cfg_data;
        REG_THR_2:     thr_r[1]    <= cfg_data;
        REG_THR_3:     thr_r[2]    <= cfg_data;
        REG_THR_4:     thr_r[3]    <= cfg_data;
        REG_THR_5:     thr_r[4]    <= cfg_data;
        REG_NUMERATOR: num_r       <= cfg_data;
        REG_SHORT_LIM: short_lim_r <= cfg_data[ADC_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- tb/tb_battery_gauge_and_supply_check_top.sv -----
// Self-checking testbench for the battery gauge and supply check block.
`timescale 1ns / 100ps

module tb_battery_gauge_and_supply_check_top;
  import bgsc_pkg::*;

  localparam int WINDOW = 1 << SAMPLES_LOG2;
  localparam int ADC_MAX = (1 << ADC_BITS) - 1;
  localparam int IN_W = $bits(in_t);
  localparam int NUM_PHASES = 7;
  localparam int BEATS_PER_PHASE = 180;
  localparam int LONG_HOLD = 400;
  localparam int DRAIN = 24;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;

  logic clk = 1'b1;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  battery_gauge_and_supply_check_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // gauge settings and window state as the block should hold them
  logic [THR_W-1:0] gauge_thr [NUM_THR];
  logic [QUOT_W-1:0] gauge_numer;
  logic [ADC_BITS-1:0] gauge_short;
  logic [SUM_W-1:0] win_sum;
  logic [CNT_W-1:0] win_count;
  logic win_kind;
  logic [LVL_W-1:0] blink_phase;

  in_t sample_beats[$];
  out_t expected_reports[$];
  out_t report_want;

  logic no_idle = 1'b0;
  int holds_asked = 0;
  int holds_done;
  int send_gap;
  int stall_left;
  int hold_left;
  int quiet_cycles = 0;
  int mismatches = 0;
  int beats_in = 0;
  int cfg_writes = 0;
  int battery_reports = 0;
  int supply_reports = 0;
  int short_reports = 0;
  int pin_reports = 0;

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void reset_gauge();
    gauge_thr[0] = RST_THR_1;
    gauge_thr[1] = RST_THR_2;
    gauge_thr[2] = RST_THR_3;
    gauge_thr[3] = RST_THR_4;
    gauge_thr[4] = RST_THR_5;
    gauge_numer = RST_NUMERATOR;
    gauge_short = RST_SHORT_LIM;
    win_sum = '0;
    win_count = '0;
    win_kind = KIND_BATTERY;
    blink_phase = '0;
  endfunction

  function automatic void apply_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    case (idx)
      REG_THR_1: gauge_thr[0] = val;
      REG_THR_2: gauge_thr[1] = val;
      REG_THR_3: gauge_thr[2] = val;
      REG_THR_4: gauge_thr[3] = val;
      REG_THR_5: gauge_thr[4] = val;
      REG_NUMERATOR: gauge_numer = val;
      REG_SHORT_LIM: gauge_short = val[ADC_BITS-1:0];
      default: ;
    endcase
  endfunction

  function automatic void predict_gauge(in_t b);
    out_t r;
    logic [ADC_BITS-1:0] avg;
    logic [QUOT_W-1:0] quot;
    int lvl;
    r = '0;
    r.result_kind = b.measure_kind;
    if (b.measure_kind == KIND_SUPPLY && (!b.charging_n || !b.standby_n)) begin
      r.supply_status = STATUS_PIN;
      win_sum = '0;
      win_count = '0;
      win_kind = KIND_SUPPLY;
      expected_reports.push_back(r);
      return;
    end
    if (b.measure_kind != win_kind || win_count >= WINDOW) begin
      win_sum = '0;
      win_count = '0;
      win_kind = b.measure_kind;
    end
    win_sum = win_sum + SUM_W'(b.sample);
    win_count = win_count + CNT_W'(1);
    if (win_count < WINDOW) return;
    avg = win_sum[SUM_W-1:SAMPLES_LOG2];
    win_sum = '0;
    win_count = '0;
    if (b.measure_kind == KIND_BATTERY) begin
      quot = (avg == 0) ? '1 : QUOT_W'(gauge_numer / QUOT_W'(avg));
      lvl = NUM_THR;
      for (int i = NUM_THR - 1; i >= 0; i--) begin
        if (quot < gauge_thr[i]) lvl = i;
      end
      if (!b.charging_n) begin
        lvl = int'(blink_phase);
        blink_phase = (blink_phase >= PHASE_LAST) ? '0 : blink_phase + LVL_W'(1);
      end
      r.level = LVL_W'(lvl);
    end else begin
      blink_phase = '0;
      if (avg < gauge_short) begin
        r.supply_status = STATUS_SHORT;
        r.output_off = 1'b1;
      end else begin
        r.supply_status = STATUS_NORMAL;
      end
    end
    expected_reports.push_back(r);
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // sender: offer queued beats with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_gauge(in_data);
        beats_in++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          in_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (sample_beats.size() != 0) begin
          in_data <= sample_beats.pop_front();
          in_valid <= 1'b1;
          send_gap <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls plus long hold-offs on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left <= 0;
      hold_left <= 0;
      holds_done <= 0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_done != holds_asked) begin
      out_ready <= 1'b0;
      hold_left <= LONG_HOLD;
      holds_done <= holds_done + 1;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_reports.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing expected, actual kind %0d level %0d status %0d off %0d",
                 $time, out_data.result_kind, out_data.level, out_data.supply_status,
                 out_data.output_off);
      end else begin
        report_want = expected_reports.pop_front();
        check_field("result_kind", int'(report_want.result_kind), int'(out_data.result_kind));
        check_field("level", int'(report_want.level), int'(out_data.level));
        check_field("supply_status", int'(report_want.supply_status),
                    int'(out_data.supply_status));
        check_field("output_off", int'(report_want.output_off), int'(out_data.output_off));
      end
      if (out_data.result_kind == KIND_BATTERY) battery_reports++;
      else supply_reports++;
      if (out_data.supply_status == STATUS_SHORT) short_reports++;
      if (out_data.result_kind == KIND_SUPPLY && out_data.supply_status == STATUS_PIN)
        pin_reports++;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, no beat moved for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, expected_reports.size());
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    apply_reg(idx, val);
    cfg_writes++;
  endtask

  task automatic program_gauge(input int ph);
    logic [CFG_W-1:0] v [NUM_THR + 2];
    int a;
    case (ph)
      1: begin
        for (int i = 0; i < NUM_THR; i++) v[i] = '0;
        v[5] = 16'd1;
        v[6] = '0;
      end
      2: begin
        for (int i = 0; i < NUM_THR; i++) v[i] = '1;
        v[5] = '1;
        v[6] = '1;
      end
      3, 6: begin
        v[5] = CFG_W'($urandom_range(1, 65535));
        v[6] = CFG_W'($urandom_range(0, 65535));
        a = $urandom_range(700, ADC_MAX);
        for (int i = 0; i < NUM_THR; i++) begin
          v[i] = CFG_W'(int'(v[5]) / a);
          a = a - $urandom_range(1, a / 5 + 1);
          if (a < 1) a = 1;
        end
      end
      4: begin
        for (int i = 0; i < NUM_THR; i++) v[i] = CFG_W'($urandom_range(0, 65535));
        v[5] = CFG_W'($urandom_range(1, 65535));
        v[6] = CFG_W'($urandom_range(0, 65535));
      end
      default: begin
        v[0] = RST_THR_1;
        v[1] = RST_THR_2;
        v[2] = RST_THR_3;
        v[3] = RST_THR_4;
        v[4] = RST_THR_5;
        v[5] = RST_NUMERATOR;
        v[6] = CFG_W'(RST_SHORT_LIM);
      end
    endcase
    write_reg(REG_THR_1, v[0]);
    write_reg(REG_THR_2, v[1]);
    write_reg(REG_THR_3, v[2]);
    write_reg(REG_THR_4, v[3]);
    write_reg(REG_THR_5, v[4]);
    write_reg(REG_NUMERATOR, v[5]);
    write_reg(REG_SHORT_LIM, v[6]);
    write_reg(REG_UNUSED, CFG_W'($urandom_range(0, 65535)));
  endtask

  task automatic push_beat(input logic kind, input int level_val, input logic chg_n,
                           input logic stby_n);
    in_t b;
    b.measure_kind = kind;
    b.sample = ADC_BITS'(level_val);
    b.charging_n = chg_n;
    b.standby_n = stby_n;
    sample_beats.push_back(b);
  endtask

  task automatic push_window(input logic kind, input int len);
    int center;
    int spread;
    int s;
    int t;
    logic chg;
    case ($urandom_range(0, 7))
      0: center = $urandom_range(0, 20);
      1: begin
        t = int'(gauge_thr[$urandom_range(0, NUM_THR - 1)]);
        if (kind == KIND_SUPPLY) center = int'(gauge_short) + $urandom_range(0, 16) - 8;
        else if (t != 0) center = int'(gauge_numer) / t;
        else center = $urandom_range(0, ADC_MAX);
      end
      2: center = ADC_MAX - $urandom_range(0, 20);
      default: center = $urandom_range(0, ADC_MAX);
    endcase
    spread = $urandom_range(0, 1) ? $urandom_range(0, 4) : $urandom_range(0, ADC_MAX);
    chg = ($urandom_range(0, 2) != 0);
    for (int i = 0; i < len; i++) begin
      s = center + $urandom_range(0, 2 * spread) - spread;
      if (s < 0) s = 0;
      if (s > ADC_MAX) s = ADC_MAX;
      if (kind == KIND_SUPPLY) push_beat(kind, s, 1'b1, 1'b1);
      else push_beat(kind, s, (i == len - 1) ? chg : 1'($urandom), 1'($urandom));
    end
  endtask

  task automatic push_random(input int n);
    int added;
    int pick;
    int len;
    added = 0;
    while (added < n) begin
      pick = $urandom_range(0, 15);
      if (pick < 13) begin
        len = (pick < 11) ? WINDOW : $urandom_range(1, WINDOW - 1);
        push_window(1'($urandom), len);
        added += len;
      end else begin
        sample_beats.push_back(in_t'(IN_W'($urandom)));
        added++;
      end
    end
  endtask

  task automatic settle();
    do @(negedge clk); while (sample_beats.size() != 0 || in_valid || expected_reports.size() != 0);
    repeat (DRAIN) @(negedge clk);
  endtask

  initial begin
    reset_gauge();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) program_gauge(ph);
      @(negedge clk);
      no_idle <= (ph == 4);
      if (ph == 3) holds_asked <= holds_asked + 1;
      if (ph == 0) begin
        push_beat(KIND_SUPPLY, 500, 1'b0, 1'b1);
        push_beat(KIND_SUPPLY, 500, 1'b1, 1'b0);
        push_beat(KIND_SUPPLY, 500, 1'b0, 1'b0);
        repeat (2) push_beat(KIND_BATTERY, ADC_MAX, 1'b1, 1'b1);
        repeat (WINDOW) push_beat(KIND_SUPPLY, ADC_MAX, 1'b1, 1'b1);
        repeat (WINDOW) push_beat(KIND_BATTERY, 0, 1'b1, 1'b0);
      end
      push_random(BEATS_PER_PHASE);
      settle();
    end
    $display("Run covered %0d sample beats over %0d register settings (%0d writes).",
             beats_in, NUM_PHASES, cfg_writes);
    $display("Results seen: %0d battery, %0d supply, %0d shorts, %0d pin-low answers.",
             battery_reports, supply_reports, short_reports, pin_reports);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
